// ===== rtl/prt_pkg.sv =====
// Shared types and constants for the point rigid transform block.
// No dependencies; every other file in rtl/ imports this package.
package prt_pkg;

    localparam int DATA_W = 32;           // Q16.16 coordinates, Q1.30 quaternion words
    localparam int PKT_W  = 3 * DATA_W;   // one packed x/y/z point
    localparam int COEF_W = 36;           // rotation matrix entry, Q.30
    localparam int NSTG   = 7;            // register stages from input to output
    localparam int ADDR_W = 5;            // byte address width; covers the highest register

    localparam logic signed [DATA_W-1:0] QUAT_ONE = 32'sh4000_0000;

    typedef enum logic [2:0] {
        REG_SHIFT_X = 3'd0,
        REG_SHIFT_Y = 3'd1,
        REG_SHIFT_Z = 3'd2,
        REG_QUAT_W  = 3'd3,
        REG_QUAT_X  = 3'd4,
        REG_QUAT_Y  = 3'd5,
        REG_QUAT_Z  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] shift_x;
        logic signed [DATA_W-1:0] shift_y;
        logic signed [DATA_W-1:0] shift_z;
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
    } t_cfg;

    // x sits in the lowest bits, matching the stream data layout
    typedef struct packed {
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] x;
    } t_point;

    typedef struct packed {
        logic signed [COEF_W-1:0] c2;
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c0;
    } t_row;

    typedef struct packed {
        t_row r2;
        t_row r1;
        t_row r0;
    } t_mat;

    // load enables of the row arithmetic stages
    typedef struct packed {
        logic mul;
        logic sum;
        logic rnd;
        logic sat;
    } t_row_ctl;

endpackage

// ===== rtl/prt_cfg.sv =====
// Configuration register file with an APB-style access port.
// Depends on prt_pkg for the register map and the register struct.
module prt_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prt_pkg::ADDR_W-1:0]  paddr,
    input  logic [prt_pkg::DATA_W-1:0]  pwdata,
    output logic [prt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output prt_pkg::t_cfg               o_cfg
);
    import prt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shift_x <= '0;
            r_cfg.shift_y <= '0;
            r_cfg.shift_z <= '0;
            r_cfg.quat_w  <= QUAT_ONE;
            r_cfg.quat_x  <= '0;
            r_cfg.quat_y  <= '0;
            r_cfg.quat_z  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_SHIFT_X: r_cfg.shift_x <= pwdata;
                REG_SHIFT_Y: r_cfg.shift_y <= pwdata;
                REG_SHIFT_Z: r_cfg.shift_z <= pwdata;
                REG_QUAT_W:  r_cfg.quat_w  <= pwdata;
                REG_QUAT_X:  r_cfg.quat_x  <= pwdata;
                REG_QUAT_Y:  r_cfg.quat_y  <= pwdata;
                REG_QUAT_Z:  r_cfg.quat_z  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SHIFT_X: prdata = r_cfg.shift_x;
            REG_SHIFT_Y: prdata = r_cfg.shift_y;
            REG_SHIFT_Z: prdata = r_cfg.shift_z;
            REG_QUAT_W:  prdata = r_cfg.quat_w;
            REG_QUAT_X:  prdata = r_cfg.quat_x;
            REG_QUAT_Y:  prdata = r_cfg.quat_y;
            REG_QUAT_Z:  prdata = r_cfg.quat_z;
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== rtl/prt_matrix.sv =====
// Two-stage derivation of the rotation matrix from the quaternion registers.
// Depends on prt_pkg for the register and matrix structs.
module prt_matrix (
    input  logic          i_clk,
    input  prt_pkg::t_cfg i_cfg,
    output prt_pkg::t_mat o_mat
);
    import prt_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int RND_SH = 29;
    localparam int TP_W   = PROD_W - RND_SH;
    localparam logic signed [PROD_W-1:0] TP_HALF = PROD_W'(1) << (RND_SH - 1);
    localparam logic signed [COEF_W-1:0] Q30_ONE = COEF_W'(1) << 30;

    // round(2*a*b) in Q.30
    function automatic logic signed [TP_W-1:0] twice_prod(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [PROD_W-1:0] p;
        p = a * b;
        p = p + TP_HALF;
        return p[PROD_W-1:RND_SH];
    endfunction

    logic signed [TP_W-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_mat                   r_mat;

    assign o_mat = r_mat;

    always_ff @(posedge i_clk) begin
        r_xx <= twice_prod(i_cfg.quat_x, i_cfg.quat_x);
        r_yy <= twice_prod(i_cfg.quat_y, i_cfg.quat_y);
        r_zz <= twice_prod(i_cfg.quat_z, i_cfg.quat_z);
        r_xy <= twice_prod(i_cfg.quat_x, i_cfg.quat_y);
        r_xz <= twice_prod(i_cfg.quat_x, i_cfg.quat_z);
        r_yz <= twice_prod(i_cfg.quat_y, i_cfg.quat_z);
        r_wx <= twice_prod(i_cfg.quat_w, i_cfg.quat_x);
        r_wy <= twice_prod(i_cfg.quat_w, i_cfg.quat_y);
        r_wz <= twice_prod(i_cfg.quat_w, i_cfg.quat_z);
    end

    always_ff @(posedge i_clk) begin
        r_mat.r0.c0 <= Q30_ONE - (COEF_W'(r_yy) + COEF_W'(r_zz));
        r_mat.r0.c1 <= COEF_W'(r_xy) - COEF_W'(r_wz);
        r_mat.r0.c2 <= COEF_W'(r_xz) + COEF_W'(r_wy);
        r_mat.r1.c0 <= COEF_W'(r_xy) + COEF_W'(r_wz);
        r_mat.r1.c1 <= Q30_ONE - (COEF_W'(r_xx) + COEF_W'(r_zz));
        r_mat.r1.c2 <= COEF_W'(r_yz) - COEF_W'(r_wx);
        r_mat.r2.c0 <= COEF_W'(r_xz) - COEF_W'(r_wy);
        r_mat.r2.c1 <= COEF_W'(r_yz) + COEF_W'(r_wx);
        r_mat.r2.c2 <= Q30_ONE - (COEF_W'(r_xx) + COEF_W'(r_yy));
    end

endmodule

// ===== rtl/prt_row.sv =====
// One output coordinate: multiply, sum, round, translate and saturate.
// Depends on prt_pkg; stage enables come from the top-level pipeline control.
module prt_row (
    input  logic                              i_clk,
    input  prt_pkg::t_row_ctl                 i_ctl,
    input  prt_pkg::t_row                     i_coef,
    input  prt_pkg::t_point                   i_point,
    input  logic signed [prt_pkg::DATA_W-1:0] i_shift,
    output logic signed [prt_pkg::DATA_W-1:0] o_moved
);
    import prt_pkg::*;

    localparam int HALF_W = DATA_W / 2;
    localparam int HI_W   = COEF_W + HALF_W;
    localparam int LO_W   = COEF_W + HALF_W + 1;
    localparam int HS_W   = HI_W + 2;
    localparam int LS_W   = LO_W + 2;
    localparam int ACC_W  = COEF_W + DATA_W + 2;
    localparam int FRAC   = 30;
    localparam int Q_W    = ACC_W - FRAC;
    localparam int V_W    = Q_W + 1;
    localparam logic signed [ACC_W-1:0] S_HALF = ACC_W'(1) << (FRAC - 1);

    logic signed [COEF_W-1:0] w_c [3];
    logic signed [DATA_W-1:0] w_p [3];
    logic signed [HI_W-1:0]   r_hi [3];
    logic signed [LO_W-1:0]   r_lo [3];
    logic signed [HS_W-1:0]   r_hs;
    logic signed [LS_W-1:0]   r_ls;
    logic signed [ACC_W-1:0]  w_s;
    logic signed [Q_W-1:0]    r_q;
    logic signed [V_W-1:0]    w_v;
    logic                     w_fit;
    logic signed [DATA_W-1:0] r_out;

    assign w_c[0] = i_coef.c0;
    assign w_c[1] = i_coef.c1;
    assign w_c[2] = i_coef.c2;
    assign w_p[0] = i_point.x;
    assign w_p[1] = i_point.y;
    assign w_p[2] = i_point.z;

    // split each coordinate into a signed high half and an unsigned low half
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            for (int i = 0; i < 3; i++) begin
                r_hi[i] <= w_c[i] * $signed(w_p[i][DATA_W-1:HALF_W]);
                r_lo[i] <= w_c[i] * $signed({1'b0, w_p[i][HALF_W-1:0]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum) begin
            r_hs <= HS_W'(r_hi[0]) + HS_W'(r_hi[1]) + HS_W'(r_hi[2]);
            r_ls <= LS_W'(r_lo[0]) + LS_W'(r_lo[1]) + LS_W'(r_lo[2]);
        end
    end

    // exact dot product, rounded once to Q16.16
    assign w_s = (ACC_W'(r_hs) <<< HALF_W) + ACC_W'(r_ls) + S_HALF;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rnd) begin
            r_q <= w_s[ACC_W-1:FRAC];
        end
    end

    assign w_v   = V_W'(r_q) + V_W'(i_shift);
    assign w_fit = (w_v[V_W-1:DATA_W-1] == {(V_W-DATA_W+1){w_v[V_W-1]}});

    always_ff @(posedge i_clk) begin
        if (i_ctl.sat) begin
            r_out <= w_fit ? w_v[DATA_W-1:0]
                           : {w_v[V_W-1], {(DATA_W-1){~w_v[V_W-1]}}};
        end
    end

    assign o_moved = r_out;

endmodule

// ===== rtl/point_rigid_transform.sv =====
// Rigid pose (quaternion rotation plus translation) applied to a stream of 3D points.
// Each input transfer passes through the stages of the stage map below to the output register.
// Throughput: one point per cycle unless the output stalls; 18 multipliers (36 x 16, 36 x 17 bits).
// Reset (synchronous, active low): empties the pipeline, translation 0, quaternion identity.
// Depends on prt_pkg, prt_cfg, prt_matrix and prt_row.
module point_rigid_transform (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input points
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [prt_pkg::PKT_W-1:0]   i_s_tdata,   // point_x, point_y, point_z
    // transformed points
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [prt_pkg::PKT_W-1:0]   o_m_tdata,   // moved_x, moved_y, moved_z
    // register access
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prt_pkg::ADDR_W-1:0]  paddr,
    input  logic [prt_pkg::DATA_W-1:0]  pwdata,
    output logic [prt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import prt_pkg::*;

    // Stage map:
    //   1     capture the input transfer
    //   2, 3  hold the point while the matrix pipe catches up with the registers
    //   4     partial products (high and low halves of each coordinate)
    //   5     sum the partial products of each row
    //   6     combine halves and round to Q16.16
    //   7     add translation, saturate; this is the output register

    t_cfg              w_cfg;
    t_mat              w_mat;
    t_row_ctl          w_ctl;
    t_point            r_p1, r_p2, r_p3;
    t_point            w_out;
    logic [NSTG:1]     r_v;
    logic [NSTG:1]     w_vin;
    logic [NSTG+1:1]   w_adv;

    prt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Matrix entries pass through the product and matrix registers of prt_matrix after a register write
    // and settle before any point accepted after the write reaches the multiply stage.
    prt_matrix u_matrix (
        .i_clk (i_clk),
        .i_cfg (w_cfg),
        .o_mat (w_mat)
    );

    // A stage advances when it is empty or the stage ahead advances; bubbles
    // collapse, so a stalled output only blocks input once the pipe is full.
    always_comb begin
        w_adv[NSTG+1] = i_m_tready;
        for (int k = NSTG; k >= 1; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign w_vin = {r_v[NSTG-1:1], i_s_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    // point payload for stages 1 to 3
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_p1 <= t_point'(i_s_tdata);
        end
        if (w_adv[2]) begin
            r_p2 <= r_p1;
        end
        if (w_adv[3]) begin
            r_p3 <= r_p2;
        end
    end

    assign w_ctl.mul = w_adv[4];
    assign w_ctl.sum = w_adv[5];
    assign w_ctl.rnd = w_adv[6];
    assign w_ctl.sat = w_adv[7];

    prt_row u_row_x (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_coef  (w_mat.r0),
        .i_point (r_p3),
        .i_shift (w_cfg.shift_x),
        .o_moved (w_out.x)
    );

    prt_row u_row_y (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_coef  (w_mat.r1),
        .i_point (r_p3),
        .i_shift (w_cfg.shift_y),
        .o_moved (w_out.y)
    );

    prt_row u_row_z (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_coef  (w_mat.r2),
        .i_point (r_p3),
        .i_shift (w_cfg.shift_z),
        .o_moved (w_out.z)
    );

    assign o_s_tready = w_adv[1];
    assign o_m_tvalid = r_v[NSTG];
    assign o_m_tdata  = w_out;

endmodule

// ===== rtl/prt_checker.sv =====
// Port-level checks for point_rigid_transform, attached to it by bind.
// Depends on prt_pkg for the pipeline depth.
module prt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [prt_pkg::PKT_W-1:0] o_m_tdata
);
    import prt_pkg::*;

    localparam int CNT_W = $clog2(NSTG + 2);

    logic             w_in_acc;
    logic             w_out_acc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_out_acc = o_m_tvalid && i_m_tready;

    // points accepted and not yet delivered
    always_comb begin
        n_cnt = r_cnt + CNT_W'(w_in_acc) - CNT_W'(w_out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NSTG))
        else $error("more points in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_cnt != '0))
        else $error("result shown with no point in flight");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (r_cnt == '0)) |-> ##(NSTG) o_m_tvalid)
        else $error("point into an empty pipe did not emerge on time");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind point_rigid_transform prt_checker u_prt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
